// ===== sv/paged_linear_suballocator_macros.svh =====
// Assertion macros for the paged linear suballocator.
`ifndef PAGED_LINEAR_SUBALLOCATOR_MACROS_SVH
`define PAGED_LINEAR_SUBALLOCATOR_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PLS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pls: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define PLS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pls: next-cycle check failed");

`endif

// ===== sv/pls_pkg.sv =====
// Types, sizes and helpers of the paged linear suballocator.
package pls_pkg;

   localparam int PAGE_SLOTS    = 16;
   localparam int RELEASE_DEPTH = 64;

   localparam int SLOT_W  = $clog2(PAGE_SLOTS);
   localparam int SCNT_W  = $clog2(PAGE_SLOTS + 1);
   localparam int QIDX_W  = $clog2(RELEASE_DEPTH);
   localparam int QCNT_W  = $clog2(RELEASE_DEPTH + 1);

   localparam int PSIZE_W = 31;
   localparam int PAGE_W  = 32;
   localparam int SIZE_W  = 32;
   localparam int ALOG_W  = 5;
   localparam int FENCE_W = 64;
   localparam int COUNT_W = 16;
   localparam int RET_W   = 7;

   localparam int REQ_DATA_W = 200;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 136;
   localparam int RSP_USER_W = 3;

   localparam logic [PSIZE_W-1:0] PSIZE_RESET = PSIZE_W'(65536);
   localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;

   typedef enum logic [1:0] {
      ACT_ALLOC   = 2'd0,
      ACT_RELEASE = 2'd1,
      ACT_RETIRE  = 2'd2,
      ACT_NOP     = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK           = 2'd0,
      ST_POOL_EMPTY   = 2'd1,
      ST_QUEUE_FULL   = 2'd2,
      ST_UNKNOWN_PAGE = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ALLOC0,
      S_ALLOC1,
      S_NEWPG,
      S_GRANT,
      S_REL,
      S_LOOK,
      S_LOOKDONE,
      S_RSCAN,
      S_RPICK,
      S_RPAGE,
      S_RDEC,
      S_COMPACT,
      S_RESP
   } state_type;

   // Wrap a ring position back into the slot range.
   function automatic logic [SLOT_W-1:0] slot_wrap(input logic [SLOT_W:0] v);
      logic [SLOT_W:0] r;
      r = v;
      if (v >= (SLOT_W + 1)'(PAGE_SLOTS)) begin
         r = v - (SLOT_W + 1)'(PAGE_SLOTS);
      end
      return r[SLOT_W-1:0];
   endfunction

endpackage

// ===== sv/paged_linear_suballocator.sv =====
// Allocate: mega check and alignment, page-end check, new page if needed, grant. Release:
// queue the entry, after a walk of every slot for non-mega releases. Retire: a queue scan
// per popped release, a slot walk per page lookup, then a compaction sweep of the queue;
// the release-queue scan goes through the single read port of the queue memory.
// One item at a time; the output register lets a result wait while the next beat is taken.
// Reset is synchronous, active high; state is ready on the first cycle, no clearing pass.
`include "paged_linear_suballocator_macros.svh"

module paged_linear_suballocator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // alloc_size, align_log2, page_id, fence_value, completed_fence, zero pad
   input  logic [pls_pkg::REQ_DATA_W-1:0]    req_tdata,
   // action, release_is_mega
   input  logic [pls_pkg::REQ_USER_W-1:0]    req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // out_page_id, out_offset, out_fence, retired_count, zero pad
   output logic [pls_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // status, out_is_mega
   output logic [pls_pkg::RSP_USER_W-1:0]    rsp_tuser,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pls_pkg::PSIZE_W-1:0]       csr_data
);
   import pls_pkg::*;

   // control and page state
   state_type                 state_ff, state_in;
   logic [PSIZE_W-1:0]        page_size_ff, page_size_in;
   logic [PAGE_W-1:0]         next_page_ff, next_page_in;
   logic [SLOT_W-1:0]         active_ff, active_in;
   logic [PSIZE_W-1:0]        active_off_ff, active_off_in;
   logic [PAGE_W-1:0]         slot_page_ff [PAGE_SLOTS];
   logic [PAGE_W-1:0]         slot_page_in [PAGE_SLOTS];
   logic [COUNT_W-1:0]        slot_cnt_ff [PAGE_SLOTS];
   logic [COUNT_W-1:0]        slot_cnt_in [PAGE_SLOTS];
   logic [PAGE_SLOTS-1:0]     slot_used_ff, slot_used_in;
   logic [SLOT_W-1:0]         fifo_ff [PAGE_SLOTS];
   logic [SLOT_W-1:0]         fifo_in [PAGE_SLOTS];
   logic [SLOT_W-1:0]         fifo_head_ff, fifo_head_in;
   logic [SCNT_W-1:0]         fifo_cnt_ff, fifo_cnt_in;
   logic [QCNT_W-1:0]         pend_cnt_ff, pend_cnt_in;
   logic [RELEASE_DEPTH-1:0]  removed_ff, removed_in;
   logic                      rsp_vld_ff, rsp_vld_in;

   // current item
   action_type                act_ff, act_in;
   logic [SIZE_W-1:0]         size_ff, size_in;
   logic [ALOG_W-1:0]         alog_ff, alog_in;
   logic [PAGE_W-1:0]         target_ff, target_in;
   logic                      mega_ff, mega_in;
   logic [FENCE_W-1:0]        fence_ff, fence_in;
   logic [FENCE_W-1:0]        done_ff, done_in;

   // sequencer work registers
   logic [PAGE_W-1:0]         off_ff, off_in;
   logic [PAGE_W:0]           sum_ff, sum_in;
   logic [SLOT_W-1:0]         look_idx_ff, look_idx_in;
   logic                      first_vld_ff, first_vld_in;
   logic [SLOT_W-1:0]         first_ff, first_in;
   logic                      match_act_ff, match_act_in;
   logic [SLOT_W-1:0]         slot_sel_ff, slot_sel_in;
   logic                      best_vld_ff, best_vld_in;
   logic [QIDX_W-1:0]         best_ff, best_in;
   logic [FENCE_W-1:0]        best_fence_ff, best_fence_in;
   logic [QCNT_W-1:0]         iss_ff, iss_in;
   logic                      dv_ff, dv_in;
   logic [QIDX_W-1:0]         didx_ff, didx_in;
   logic [QCNT_W-1:0]         wr_ff, wr_in;
   logic [QCNT_W-1:0]         n_ff, n_in;

   // result
   status_type                res_status_ff, res_status_in;
   logic [PAGE_W-1:0]         res_page_ff, res_page_in;
   logic [PSIZE_W-1:0]        res_off_ff, res_off_in;
   logic                      res_mega_ff, res_mega_in;
   logic [FENCE_W-1:0]        res_fence_ff, res_fence_in;
   logic [RSP_DATA_W-1:0]     rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0]     rsp_user_ff, rsp_user_in;

   // release queue memory
   logic [FENCE_W-1:0]        fence_mem [RELEASE_DEPTH];
   logic [PAGE_W:0]           page_mem [RELEASE_DEPTH];
   logic [FENCE_W-1:0]        fence_q;
   logic [PAGE_W:0]           page_q;
   logic                      mem_we;
   logic [QIDX_W-1:0]         mem_wa, mem_ra;
   logic [FENCE_W-1:0]        mem_wf;
   logic [PAGE_W:0]           mem_wp;

   // shared adder, slot read port and helpers
   logic [PAGE_W:0]           add_a, add_b, add_s;
   logic [PAGE_W-1:0]         align_mask;
   logic [SLOT_W-1:0]         slot_ra;
   logic [PAGE_W-1:0]         slot_rpage;
   logic [COUNT_W-1:0]        slot_rcnt;
   logic                      slot_rused;
   logic                      fresh_vld;
   logic [SLOT_W-1:0]         fresh;
   logic                      req_acc;
   logic                      cand;
   logic                      found;
   logic [SLOT_W-1:0]         c_slot;
   logic [SLOT_W-1:0]         head_pop;
   logic [SCNT_W-1:0]         cnt_pop;
   logic                      pool_ok;
   logic [COUNT_W-1:0]        dec_cnt;

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   assign add_s      = add_a + add_b;
   assign align_mask = (PAGE_W'(1) << alog_ff) - PAGE_W'(1);

   // one slot read address per cycle, chosen by the sequencer
   always_comb begin
      unique case (state_ff)
         S_LOOK:  slot_ra = look_idx_ff;
         S_RDEC:  slot_ra = slot_sel_ff;
         default: slot_ra = active_ff;
      endcase
   end
   assign slot_rpage = slot_page_ff[slot_ra];
   assign slot_rcnt  = slot_cnt_ff[slot_ra];
   assign slot_rused = slot_used_ff[slot_ra];

   // lowest unused slot other than the active one
   always_comb begin
      fresh_vld = 1'b0;
      fresh     = '0;
      for (int i = PAGE_SLOTS - 1; i >= 0; i--) begin
         if (!slot_used_ff[i] && (SLOT_W'(i) != active_ff)) begin
            fresh_vld = 1'b1;
            fresh     = SLOT_W'(i);
         end
      end
   end

   // candidate for the next retire pop
   assign cand = dv_ff && !removed_ff[didx_ff] && (fence_q <= done_ff) &&
                 (!best_vld_ff || (fence_q < best_fence_ff));
   assign found = match_act_ff || first_vld_ff;

   // new page selection
   always_comb begin
      c_slot   = fresh;
      head_pop = fifo_head_ff;
      cnt_pop  = fifo_cnt_ff;
      pool_ok  = fresh_vld;
      if (fifo_cnt_ff != '0) begin
         c_slot   = fifo_ff[fifo_head_ff];
         head_pop = slot_wrap({1'b0, fifo_head_ff} + (SLOT_W + 1)'(1));
         cnt_pop  = fifo_cnt_ff - SCNT_W'(1);
         pool_ok  = 1'b1;
      end
   end

   assign dec_cnt = (slot_rcnt != '0) ? slot_rcnt - COUNT_W'(1) : '0;

   // sequencer: next state and datapath
   always_comb begin
      state_in      = state_ff;
      page_size_in  = page_size_ff;
      next_page_in  = next_page_ff;
      active_in     = active_ff;
      active_off_in = active_off_ff;
      slot_page_in  = slot_page_ff;
      slot_cnt_in   = slot_cnt_ff;
      slot_used_in  = slot_used_ff;
      fifo_in       = fifo_ff;
      fifo_head_in  = fifo_head_ff;
      fifo_cnt_in   = fifo_cnt_ff;
      pend_cnt_in   = pend_cnt_ff;
      removed_in    = removed_ff;
      rsp_vld_in    = rsp_vld_ff;
      act_in        = act_ff;
      size_in       = size_ff;
      alog_in       = alog_ff;
      target_in     = target_ff;
      mega_in       = mega_ff;
      fence_in      = fence_ff;
      done_in       = done_ff;
      off_in        = off_ff;
      sum_in        = sum_ff;
      look_idx_in   = look_idx_ff;
      first_vld_in  = first_vld_ff;
      first_in      = first_ff;
      match_act_in  = match_act_ff;
      slot_sel_in   = slot_sel_ff;
      best_vld_in   = best_vld_ff;
      best_in       = best_ff;
      best_fence_in = best_fence_ff;
      iss_in        = iss_ff;
      dv_in         = 1'b0;
      didx_in       = didx_ff;
      wr_in         = wr_ff;
      n_in          = n_ff;
      res_status_in = res_status_ff;
      res_page_in   = res_page_ff;
      res_off_in    = res_off_ff;
      res_mega_in   = res_mega_ff;
      res_fence_in  = res_fence_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;
      mem_we        = 1'b0;
      mem_wa        = pend_cnt_ff[QIDX_W-1:0];
      mem_wf        = fence_ff;
      mem_wp        = {1'b0, target_ff};
      mem_ra        = iss_ff[QIDX_W-1:0];
      add_a         = {2'b0, active_off_ff};
      add_b         = {1'b0, align_mask};

      // output register drains independently
      if (rsp_vld_ff && rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
      if (csr_valid && csr_ready) begin
         page_size_in = csr_data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               act_in        = action_type'(req_tuser[1:0]);
               mega_in       = req_tuser[2];
               size_in       = req_tdata[31:0];
               alog_in       = req_tdata[36:32];
               target_in     = req_tdata[68:37];
               fence_in      = req_tdata[132:69];
               done_in       = req_tdata[196:133];
               res_status_in = ST_OK;
               res_page_in   = '0;
               res_off_in    = '0;
               res_mega_in   = 1'b0;
               res_fence_in  = '0;
               n_in          = '0;
               iss_in        = '0;
               best_vld_in   = 1'b0;
               unique case (action_type'(req_tuser[1:0]))
                  ACT_ALLOC:   state_in = S_ALLOC0;
                  ACT_RELEASE: state_in = S_REL;
                  ACT_RETIRE:  state_in = S_RSCAN;
                  ACT_NOP:     state_in = S_RESP;
               endcase
            end
         end

         // mega check and alignment of the bump pointer
         S_ALLOC0: begin
            if ({1'b0, size_ff} > {2'b0, page_size_ff}) begin
               res_mega_in  = 1'b1;
               res_fence_in = fence_ff;
               state_in     = S_RESP;
            end else begin
               off_in   = add_s[PAGE_W-1:0] & ~align_mask;
               state_in = S_ALLOC1;
            end
         end

         // end of the request against the page end
         S_ALLOC1: begin
            add_a  = {1'b0, off_ff};
            add_b  = {1'b0, size_ff};
            sum_in = add_s;
            if (add_s > {2'b0, page_size_ff}) begin
               state_in = S_NEWPG;
            end else begin
               state_in = S_GRANT;
            end
         end

         // retire the active page and open another
         S_NEWPG: begin
            if (!pool_ok) begin
               res_status_in = ST_POOL_EMPTY;
               state_in      = S_RESP;
            end else begin
               fifo_head_in = head_pop;
               fifo_cnt_in  = cnt_pop;
               if (slot_rcnt == '0) begin
                  slot_used_in[active_ff] = 1'b0;
                  if (cnt_pop < SCNT_W'(PAGE_SLOTS)) begin
                     fifo_in[slot_wrap((SLOT_W + 1)'(head_pop) + (SLOT_W + 1)'(cnt_pop))] =
                        active_ff;
                     fifo_cnt_in = cnt_pop + SCNT_W'(1);
                  end
               end
               next_page_in         = next_page_ff + PAGE_W'(1);
               slot_used_in[c_slot] = 1'b1;
               slot_cnt_in[c_slot]  = '0;
               slot_page_in[c_slot] = next_page_ff + PAGE_W'(1);
               active_in            = c_slot;
               off_in               = '0;
               sum_in               = {1'b0, size_ff};
               state_in             = S_GRANT;
            end
         end

         S_GRANT: begin
            if (slot_rcnt != COUNT_MAX) begin
               slot_cnt_in[active_ff] = slot_rcnt + COUNT_W'(1);
            end
            active_off_in = sum_ff[PSIZE_W-1:0];
            res_page_in   = slot_rpage;
            res_off_in    = off_ff[PSIZE_W-1:0];
            res_fence_in  = fence_ff;
            state_in      = S_RESP;
         end

         S_REL: begin
            if (pend_cnt_ff >= QCNT_W'(RELEASE_DEPTH)) begin
               res_status_in = ST_QUEUE_FULL;
               state_in      = S_RESP;
            end else if (mega_ff) begin
               mem_we      = 1'b1;
               mem_wp      = {1'b1, {PAGE_W{1'b0}}};
               pend_cnt_in = pend_cnt_ff + QCNT_W'(1);
               state_in    = S_RESP;
            end else begin
               look_idx_in  = '0;
               first_vld_in = 1'b0;
               match_act_in = 1'b0;
               state_in     = S_LOOK;
            end
         end

         // walk the slots for the target page number
         S_LOOK: begin
            if (slot_rused && (slot_rpage == target_ff)) begin
               if (!first_vld_ff) begin
                  first_vld_in = 1'b1;
                  first_in     = look_idx_ff;
               end
               if (look_idx_ff == active_ff) begin
                  match_act_in = 1'b1;
               end
            end
            look_idx_in = look_idx_ff + SLOT_W'(1);
            if (look_idx_ff == SLOT_W'(PAGE_SLOTS - 1)) begin
               state_in = S_LOOKDONE;
            end
         end

         S_LOOKDONE: begin
            slot_sel_in = match_act_ff ? active_ff : first_ff;
            if (act_ff == ACT_RELEASE) begin
               if (found) begin
                  mem_we      = 1'b1;
                  pend_cnt_in = pend_cnt_ff + QCNT_W'(1);
               end else begin
                  res_status_in = ST_UNKNOWN_PAGE;
               end
               state_in = S_RESP;
            end else if (found) begin
               state_in = S_RDEC;
            end else begin
               iss_in      = '0;
               best_vld_in = 1'b0;
               state_in    = S_RSCAN;
            end
         end

         // scan the queue for the lowest completed fence
         S_RSCAN: begin
            if (cand) begin
               best_vld_in   = 1'b1;
               best_in       = didx_ff;
               best_fence_in = fence_q;
            end
            if (iss_ff < pend_cnt_ff) begin
               iss_in  = iss_ff + QCNT_W'(1);
               dv_in   = 1'b1;
               didx_in = iss_ff[QIDX_W-1:0];
            end else if (!dv_ff) begin
               state_in = S_RPICK;
            end
         end

         S_RPICK: begin
            mem_ra = best_ff;
            if (best_vld_ff) begin
               removed_in[best_ff] = 1'b1;
               n_in                = n_ff + QCNT_W'(1);
               state_in            = S_RPAGE;
            end else if (n_ff == '0) begin
               state_in = S_RESP;
            end else begin
               iss_in   = '0;
               wr_in    = '0;
               state_in = S_COMPACT;
            end
         end

         S_RPAGE: begin
            iss_in      = '0;
            best_vld_in = 1'b0;
            if (page_q[PAGE_W]) begin
               state_in = S_RSCAN;
            end else begin
               target_in    = page_q[PAGE_W-1:0];
               look_idx_in  = '0;
               first_vld_in = 1'b0;
               match_act_in = 1'b0;
               state_in     = S_LOOK;
            end
         end

         // drop one allocation from the page
         S_RDEC: begin
            slot_cnt_in[slot_sel_ff] = dec_cnt;
            if (dec_cnt == '0) begin
               if (slot_sel_ff == active_ff) begin
                  active_off_in = '0;
               end else begin
                  slot_used_in[slot_sel_ff] = 1'b0;
                  if (fifo_cnt_ff < SCNT_W'(PAGE_SLOTS)) begin
                     fifo_in[slot_wrap((SLOT_W + 1)'(fifo_head_ff) +
                                       (SLOT_W + 1)'(fifo_cnt_ff))] = slot_sel_ff;
                     fifo_cnt_in = fifo_cnt_ff + SCNT_W'(1);
                  end
               end
            end
            iss_in      = '0;
            best_vld_in = 1'b0;
            state_in    = S_RSCAN;
         end

         // squeeze out popped entries, keeping order
         S_COMPACT: begin
            if (dv_ff && !removed_ff[didx_ff]) begin
               mem_we = 1'b1;
               mem_wa = wr_ff[QIDX_W-1:0];
               mem_wf = fence_q;
               mem_wp = page_q;
               wr_in  = wr_ff + QCNT_W'(1);
            end
            if (iss_ff < pend_cnt_ff) begin
               iss_in  = iss_ff + QCNT_W'(1);
               dv_in   = 1'b1;
               didx_in = iss_ff[QIDX_W-1:0];
            end else if (!dv_ff) begin
               pend_cnt_in = wr_ff;
               removed_in  = '0;
               state_in    = S_RESP;
            end
         end

         S_RESP: begin
            if (!rsp_vld_ff || rsp_tready) begin
               rsp_vld_in  = 1'b1;
               rsp_data_in = {2'b0, RET_W'(n_ff), res_fence_ff, res_off_ff, res_page_ff};
               rsp_user_in = {res_mega_ff, res_status_ff};
               state_in    = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         page_size_ff  <= PSIZE_RESET;
         next_page_ff  <= PAGE_W'(1);
         active_ff     <= '0;
         active_off_ff <= '0;
         for (int i = 0; i < PAGE_SLOTS; i++) begin
            slot_page_ff[i] <= (i == 0) ? PAGE_W'(1) : '0;
            slot_cnt_ff[i]  <= '0;
         end
         slot_used_ff  <= PAGE_SLOTS'(1);
         fifo_head_ff  <= '0;
         fifo_cnt_ff   <= '0;
         pend_cnt_ff   <= '0;
         removed_ff    <= '0;
         rsp_vld_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         page_size_ff  <= page_size_in;
         next_page_ff  <= next_page_in;
         active_ff     <= active_in;
         active_off_ff <= active_off_in;
         slot_page_ff  <= slot_page_in;
         slot_cnt_ff   <= slot_cnt_in;
         slot_used_ff  <= slot_used_in;
         fifo_head_ff  <= fifo_head_in;
         fifo_cnt_ff   <= fifo_cnt_in;
         pend_cnt_ff   <= pend_cnt_in;
         removed_ff    <= removed_in;
         rsp_vld_ff    <= rsp_vld_in;
      end
   end

   // payload and work registers
   always_ff @(posedge clock) begin
      fifo_ff       <= fifo_in;
      act_ff        <= act_in;
      size_ff       <= size_in;
      alog_ff       <= alog_in;
      target_ff     <= target_in;
      mega_ff       <= mega_in;
      fence_ff      <= fence_in;
      done_ff       <= done_in;
      off_ff        <= off_in;
      sum_ff        <= sum_in;
      look_idx_ff   <= look_idx_in;
      first_vld_ff  <= first_vld_in;
      first_ff      <= first_in;
      match_act_ff  <= match_act_in;
      slot_sel_ff   <= slot_sel_in;
      best_vld_ff   <= best_vld_in;
      best_ff       <= best_in;
      best_fence_ff <= best_fence_in;
      iss_ff        <= iss_in;
      dv_ff         <= dv_in;
      didx_ff       <= didx_in;
      wr_ff         <= wr_in;
      n_ff          <= n_in;
      res_status_ff <= res_status_in;
      res_page_ff   <= res_page_in;
      res_off_ff    <= res_off_in;
      res_mega_ff   <= res_mega_in;
      res_fence_ff  <= res_fence_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_user_ff   <= rsp_user_in;
   end

   // release queue memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         fence_mem[mem_wa] <= mem_wf;
         page_mem[mem_wa]  <= mem_wp;
      end
      fence_q <= fence_mem[mem_ra];
      page_q  <= page_mem[mem_ra];
   end

   // checks
   `PLS_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_acc, state_ff != S_IDLE)
   `PLS_ASSERT_NOW(a_queue_bound, clock, reset, 1'b1, pend_cnt_ff <= QCNT_W'(RELEASE_DEPTH))
   `PLS_ASSERT_NOW(a_fifo_bound, clock, reset, 1'b1, fifo_cnt_ff <= SCNT_W'(PAGE_SLOTS))
   `PLS_ASSERT_NOW(a_active_used, clock, reset, 1'b1, slot_used_ff[active_ff])

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the paged linear suballocator: random and directed beats.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pls_pkg::*;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] size;
      logic [4:0]  alog;
      logic [31:0] page;
      logic        mega;
      logic [63:0] fence;
      logic [63:0] done;
   } req_item;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] page;
      logic [30:0] offset;
      logic        mega;
      logic [63:0] fence;
      logic [6:0]  retired;
   } grant_item;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic csr_valid = 0;
   logic csr_ready;
   logic [PSIZE_W-1:0] csr_data = '0;

   paged_linear_suballocator dut (.*);

   initial forever #5 clock = ~clock;

   // predictor state
   logic [30:0] pg_size;
   logic [31:0] next_pg;
   int          act_slot;
   logic [30:0] act_off;
   logic [31:0] slot_pg [PAGE_SLOTS];
   logic [15:0] slot_cnt [PAGE_SLOTS];
   bit          slot_live [PAGE_SLOTS];
   int          free_q [$];
   logic [63:0] rel_fence [$];
   logic [32:0] rel_page [$];

   req_item   pending_reqs [$];
   grant_item expected_grants [$];
   int send_idle = 0, recv_stall = 0;
   int mismatches = 0, watchdog = 0;
   bit done_stim = 0;
   bit req_taken = 0;
   logic [31:0] known_pages [$];

   task automatic model_reset();
      pg_size = 31'd65536; next_pg = 1; act_slot = 0; act_off = 0;
      for (int s = 0; s < PAGE_SLOTS; s++) begin
         slot_pg[s] = 0; slot_cnt[s] = 0; slot_live[s] = 0;
      end
      slot_pg[0] = 1; slot_live[0] = 1;
      free_q = {}; rel_fence = {}; rel_page = {};
   endtask

   function automatic int find_slot(logic [31:0] p);
      if (slot_live[act_slot] && slot_pg[act_slot] == p) return act_slot;
      for (int s = 0; s < PAGE_SLOTS; s++)
         if (slot_live[s] && slot_pg[s] == p) return s;
      return PAGE_SLOTS;
   endfunction

   function automatic void free_slot(int s);
      slot_live[s] = 0;
      if (free_q.size() < PAGE_SLOTS) free_q.push_back(s);
   endfunction

   function automatic grant_item predict_grant(req_item r);
      grant_item g;
      logic [63:0] mask, off;
      int c, old, best, s, n;
      logic [32:0] pw;
      g = '0;
      case (action_type'(r.action))
         ACT_ALLOC: begin
            mask = (64'd1 << r.alog) - 1;
            if (r.size > pg_size) begin
               g.mega = 1; g.fence = r.fence; return g;
            end
            off = ({33'd0, act_off} + mask) & ~mask;
            if (off + r.size > pg_size) begin
               old = act_slot; c = PAGE_SLOTS;
               if (free_q.size() > 0) c = free_q.pop_front();
               else
                  for (int i = 0; i < PAGE_SLOTS; i++)
                     if (!slot_live[i] && i != old) begin c = i; break; end
               if (c >= PAGE_SLOTS) begin
                  g.status = ST_POOL_EMPTY; return g;
               end
               if (slot_cnt[old] == 0) free_slot(old);
               next_pg++;
               slot_live[c] = 1; slot_cnt[c] = 0; slot_pg[c] = next_pg;
               act_slot = c; off = 0;
               known_pages.push_back(next_pg);
            end
            if (slot_cnt[act_slot] != COUNT_MAX) slot_cnt[act_slot]++;
            act_off = 31'(off + r.size);
            g.page = slot_pg[act_slot]; g.offset = 31'(off); g.fence = r.fence;
         end
         ACT_RELEASE: begin
            if (rel_fence.size() >= RELEASE_DEPTH) g.status = ST_QUEUE_FULL;
            else if (!r.mega && find_slot(r.page) >= PAGE_SLOTS)
               g.status = ST_UNKNOWN_PAGE;
            else begin
               rel_fence.push_back(r.fence);
               rel_page.push_back(r.mega ? {1'b1, 32'd0} : {1'b0, r.page});
            end
         end
         ACT_RETIRE: begin
            n = 0;
            forever begin
               best = -1;
               foreach (rel_fence[i])
                  if (rel_fence[i] <= r.done && (best < 0 || rel_fence[i] < rel_fence[best]))
                     best = i;
               if (best < 0) break;
               pw = rel_page[best];
               rel_fence.delete(best); rel_page.delete(best);
               n++;
               if (!pw[32]) begin
                  s = find_slot(pw[31:0]);
                  if (s < PAGE_SLOTS) begin
                     if (slot_cnt[s] > 0) slot_cnt[s]--;
                     if (slot_cnt[s] == 0) begin
                        if (s == act_slot) act_off = 0;
                        else free_slot(s);
                     end
                  end
               end
            end
            g.retired = 7'(n);
         end
         default: ;
      endcase
      return g;
   endfunction

   // accepted beats feed the predictor
   always @(posedge clock) begin
      req_taken = !reset && req_tvalid && req_tready;
      if (req_taken)
         expected_grants.push_back(predict_grant(pending_reqs.pop_front()));
   end

   // driver: a beat stays on the bus until it is accepted
   always @(negedge clock) begin
      if (!reset) begin
         if (req_tvalid && !req_taken) begin
            // hold the waiting beat
         end else if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle) begin
            req_tvalid <= 1;
            req_tdata <= {8'd0, pending_reqs[0].done, pending_reqs[0].fence,
                          pending_reqs[0].page, pending_reqs[0].alog, pending_reqs[0].size};
            req_tuser <= {pending_reqs[0].mega, pending_reqs[0].action};
         end else req_tvalid <= 0;
         rsp_tready <= ($urandom_range(99) >= recv_stall);
      end
   end

   // monitor
   always @(posedge clock) begin
      grant_item got, want;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_valid)
            watchdog <= 0;
         else
            watchdog <= watchdog + 1;
         if (rsp_tvalid && rsp_tready) begin
            got.status = rsp_tuser[1:0]; got.mega = rsp_tuser[2];
            got.page = rsp_tdata[31:0]; got.offset = rsp_tdata[62:32];
            got.fence = rsp_tdata[126:63]; got.retired = rsp_tdata[133:127];
            if (expected_grants.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected beat %p", got);
            end else begin
               want = expected_grants.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10) $display("expected %p got %p", want, got);
               end
            end
         end
         if (watchdog > 40000) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic req_item rand_req(int kind, logic [30:0] ps);
      req_item r;
      r = '0;
      r.action = 2'(kind);
      r.alog = 5'($urandom_range(0, ($urandom_range(9) == 0) ? 31 : 8));
      r.size = ($urandom_range(19) == 0) ? $urandom : $urandom_range(0, ps / 4 + 1);
      if ($urandom_range(9) == 0) r.size = {1'b0, ps} + $urandom_range(0, 2) - 1;
      r.fence = ($urandom_range(9) == 0) ? rand64() : 64'($urandom_range(0, 300));
      r.done = ($urandom_range(9) == 0) ? rand64() : 64'($urandom_range(0, 300));
      r.mega = ($urandom_range(7) == 0);
      if (known_pages.size() > 0 && $urandom_range(4) != 0)
         r.page = known_pages[$urandom_range(0, known_pages.size() - 1)];
      else r.page = $urandom;
      return r;
   endfunction

   task automatic wait_drain();
      while (pending_reqs.size() > 0 || expected_grants.size() > 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic write_page_size(logic [30:0] v);
      @(negedge clock);
      csr_valid <= 1; csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      pg_size = v;
      @(negedge clock);
      csr_valid <= 0;
   endtask

   initial begin
      req_item r;
      int phase_idle [4] = '{0, 61, 0, 31};
      int phase_stall [4] = '{0, 0, 61, 31};
      logic [30:0] sizes [4] = '{31'd65536, 31'd64, 31'd1 << 30, 31'd300};
      model_reset();
      known_pages.push_back(1);
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: extremes, every action, special cases
      r = '0; r.action = ACT_ALLOC; r.size = 0; r.fence = '1; pending_reqs.push_back(r);
      r.size = 32'hFFFF_FFFF; pending_reqs.push_back(r);
      r.size = 65536; r.alog = 31; pending_reqs.push_back(r);
      r.size = 100; r.alog = 16; pending_reqs.push_back(r);
      r.size = 7; r.alog = 0; r.fence = 0; pending_reqs.push_back(r);
      r = '0; r.action = ACT_RELEASE; r.page = 32'hFFFF_FFFF; pending_reqs.push_back(r);
      r.page = 2; r.fence = 5; pending_reqs.push_back(r);
      r.fence = 5; pending_reqs.push_back(r);
      r.mega = 1; r.fence = '1; pending_reqs.push_back(r);
      r = '0; r.action = ACT_RETIRE; r.done = 4; pending_reqs.push_back(r);
      r.done = '1; pending_reqs.push_back(r);
      r = '0; r.action = ACT_NOP; r.size = '1; r.page = '1; r.mega = 1;
      r.fence = '1; r.done = '1; r.alog = '1; pending_reqs.push_back(r);
      r = '0; r.action = ACT_RELEASE; r.page = 1; r.fence = 9; pending_reqs.push_back(r);
      r = '0; r.action = ACT_RETIRE; pending_reqs.push_back(r);
      wait_drain();

      for (int ph = 0; ph < 4; ph++) begin
         send_idle = phase_idle[ph]; recv_stall = phase_stall[ph];
         write_page_size(sizes[ph]);
         for (int i = 0; i < 170; i++) begin
            int k;
            k = $urandom_range(99);
            // mostly alloc/release, bursts of releases to fill the queue
            if (k < 40) r = rand_req(ACT_ALLOC, pg_size);
            else if (k < 80) r = rand_req(ACT_RELEASE, pg_size);
            else if (k < 97) r = rand_req(ACT_RETIRE, pg_size);
            else r = rand_req(ACT_NOP, pg_size);
            if (ph == 2 && i < 70) begin
               r = rand_req(ACT_RELEASE, pg_size); r.mega = 1;
            end
            pending_reqs.push_back(r);
            while (pending_reqs.size() > 4) @(posedge clock);
         end
         wait_drain();
      end
      write_page_size(31'h7FFF_FFFF);
      r = rand_req(ACT_ALLOC, pg_size); pending_reqs.push_back(r);
      wait_drain();
      if (mismatches == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end
endmodule
